// File: src/fpr_pkg.sv
// shared types and constants for the fifo page replacement block
// no dependencies
`default_nettype none

package fpr_pkg;

  localparam int PAGE_W          = 16;
  localparam int STAMP_W         = 64;
  localparam int DEF_NUM_FRAMES  = 8;
  localparam int DEF_PAGE_BITS   = 16;

  localparam logic [STAMP_W-1:0] STAMP_INIT = STAMP_W'(1);

  typedef struct packed {
    logic active;
    logic found;
    logic have_min;
    logic min_valid;
  } fpr_ctl_t;

endpackage

`default_nettype wire

// File: src/fpr_cell.sv
// one frame cell: holds valid, page and placement stamp of a frame,
// folds them into the search beat passing through and registers it
// depends on fpr_pkg
`default_nettype none

module fpr_cell #(
  parameter int PAGE_BITS = fpr_pkg::DEF_PAGE_BITS,
  parameter int IDX_BITS  = 3,
  parameter int INDEX     = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fpr_pkg::fpr_ctl_t           ctl_in,
  input  wire logic [PAGE_BITS-1:0]        req_in,
  input  wire logic [IDX_BITS-1:0]         found_idx_in,
  input  wire logic [IDX_BITS-1:0]         min_idx_in,
  input  wire logic [fpr_pkg::STAMP_W-1:0] min_stamp_in,
  input  wire logic [PAGE_BITS-1:0]        min_page_in,
  output fpr_pkg::fpr_ctl_t                ctl_out,
  output logic [PAGE_BITS-1:0]             req_out,
  output logic [IDX_BITS-1:0]              found_idx_out,
  output logic [IDX_BITS-1:0]              min_idx_out,
  output logic [fpr_pkg::STAMP_W-1:0]      min_stamp_out,
  output logic [PAGE_BITS-1:0]             min_page_out,
  input  wire logic                        wr,
  input  wire logic [PAGE_BITS-1:0]        wr_page,
  input  wire logic [fpr_pkg::STAMP_W-1:0] wr_stamp
);

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);

  logic                        valid;
  logic [PAGE_BITS-1:0]        page;
  logic [fpr_pkg::STAMP_W-1:0] stamp;

  fpr_pkg::fpr_ctl_t           ctl_next;
  logic [IDX_BITS-1:0]         found_idx_next;
  logic [IDX_BITS-1:0]         min_idx_next;
  logic [fpr_pkg::STAMP_W-1:0] min_stamp_next;
  logic [PAGE_BITS-1:0]        min_page_next;
  logic                        take_min;

  always_comb begin
    ctl_next       = ctl_in;
    found_idx_next = found_idx_in;
    min_idx_next   = min_idx_in;
    min_stamp_next = min_stamp_in;
    min_page_next  = min_page_in;
    take_min       = !ctl_in.have_min || (stamp < min_stamp_in);
    if (!ctl_in.found && valid && (page == req_in)) begin
      ctl_next.found = 1'b1;
      found_idx_next = MY_IDX;
    end
    if (take_min) begin
      ctl_next.have_min  = 1'b1;
      ctl_next.min_valid = valid;
      min_idx_next       = MY_IDX;
      min_stamp_next     = stamp;
      min_page_next      = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      stamp <= '0;
    end else if (wr) begin
      valid <= 1'b1;
      stamp <= wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      page <= wr_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    req_out       <= req_in;
    found_idx_out <= found_idx_next;
    min_idx_out   <= min_idx_next;
    min_stamp_out <= min_stamp_next;
    min_page_out  <= min_page_next;
  end

endmodule

`default_nettype wire

// File: src/fifo_page_replacement.sv
// top level of the fifo page replacement block: chain of frame cells,
// time counter and result register
// depends on fpr_pkg and fpr_cell
//
// usage:
//   a request beat is taken at a rising edge with start high and busy low.
//   the request enters the first frame cell and moves one cell per cycle;
//   each cell checks for a page match and keeps the oldest stamp seen so far.
//   when the beat leaves the last cell the result is registered: done is
//   high for exactly one cycle with hit, frame_index, evicted_valid and
//   evicted_page. on a miss the chosen frame is loaded at that same edge.
//   the beat passes through the chain of frame cells and then the result
//   register; busy drops in the cycle done is shown, so a new request is
//   taken only after the previous one has produced its result.
//   the receiver cannot stall: each result must be taken while done is high.
//   reset (rst, synchronous) empties all frames, clears stamps and sets the
//   time counter to one; no clearing pass is needed.
`default_nettype none

module fifo_page_replacement #(
  parameter int NUM_FRAMES = fpr_pkg::DEF_NUM_FRAMES,
  parameter int PAGE_BITS  = fpr_pkg::DEF_PAGE_BITS,
  localparam int IDX_BITS  = $clog2(NUM_FRAMES)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [fpr_pkg::PAGE_W-1:0] requested_page,
  output logic                            done,
  output logic                            hit,
  output logic [IDX_BITS-1:0]             frame_index,
  output logic                            evicted_valid,
  output logic [fpr_pkg::PAGE_W-1:0]      evicted_page
);

  fpr_pkg::fpr_ctl_t           ctl       [0:NUM_FRAMES];
  logic [PAGE_BITS-1:0]        req       [0:NUM_FRAMES];
  logic [IDX_BITS-1:0]         found_idx [0:NUM_FRAMES];
  logic [IDX_BITS-1:0]         min_idx   [0:NUM_FRAMES];
  logic [fpr_pkg::STAMP_W-1:0] min_stamp [0:NUM_FRAMES];
  logic [PAGE_BITS-1:0]        min_page  [0:NUM_FRAMES];

  fpr_pkg::fpr_ctl_t           ctl_head;
  logic [fpr_pkg::STAMP_W-1:0] time_counter;
  logic                        accept;
  logic                        tail_active;
  logic                        miss;
  logic [NUM_FRAMES-1:0]       wr;
  logic [IDX_BITS-1:0]         sel;

  assign accept      = start && !busy;
  assign tail_active = ctl[NUM_FRAMES].active;
  assign miss        = tail_active && !ctl[NUM_FRAMES].found;
  assign sel         = ctl[NUM_FRAMES].found ? found_idx[NUM_FRAMES] : min_idx[NUM_FRAMES];

  always_comb begin
    ctl_head        = '0;
    ctl_head.active = accept;
  end

  assign ctl[0]       = ctl_head;
  assign req[0]       = PAGE_BITS'(requested_page);
  assign found_idx[0] = '0;
  assign min_idx[0]   = '0;
  assign min_stamp[0] = '0;
  assign min_page[0]  = '0;

  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      wr[i] = miss && (min_idx[NUM_FRAMES] == IDX_BITS'(i));
    end
  end

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    fpr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .IDX_BITS  (IDX_BITS),
      .INDEX     (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl_in        (ctl[g]),
      .req_in        (req[g]),
      .found_idx_in  (found_idx[g]),
      .min_idx_in    (min_idx[g]),
      .min_stamp_in  (min_stamp[g]),
      .min_page_in   (min_page[g]),
      .ctl_out       (ctl[g+1]),
      .req_out       (req[g+1]),
      .found_idx_out (found_idx[g+1]),
      .min_idx_out   (min_idx[g+1]),
      .min_stamp_out (min_stamp[g+1]),
      .min_page_out  (min_page[g+1]),
      .wr            (wr[g]),
      .wr_page       (req[NUM_FRAMES]),
      .wr_stamp      (time_counter)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      done         <= 1'b0;
      time_counter <= fpr_pkg::STAMP_INIT;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (tail_active) begin
        busy <= 1'b0;
      end
      done <= tail_active;
      if (tail_active) begin
        time_counter <= time_counter + fpr_pkg::STAMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_active) begin
      hit           <= ctl[NUM_FRAMES].found;
      frame_index   <= sel;
      evicted_valid <= miss && ctl[NUM_FRAMES].min_valid;
      evicted_page  <= (miss && ctl[NUM_FRAMES].min_valid)
                       ? fpr_pkg::PAGE_W'(min_page[NUM_FRAMES]) : '0;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench for fifo_page_replacement: directed and random page requests,
// results checked beat by beat against an in-bench frame table
// depends on fpr_pkg and the fifo_page_replacement rtl

module tb;

  localparam int FRAMES = fpr_pkg::DEF_NUM_FRAMES;
  localparam int PW     = fpr_pkg::PAGE_W;
  localparam int SW     = fpr_pkg::STAMP_W;
  localparam int IDX_W  = $clog2(FRAMES);
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1400;

  typedef struct {
    logic             hit;
    logic [IDX_W-1:0] frame;
    logic             ev_valid;
    logic [PW-1:0]    ev_page;
  } placement_t;

  class frame_table_sb;
    bit            frame_used [FRAMES];
    logic [PW-1:0] frame_page [FRAMES];
    logic [SW-1:0] placed_at [FRAMES];
    logic [SW-1:0] stamp_now;
    placement_t    expected_placements [$];
    int            errors;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        frame_used[i] = 1'b0;
        frame_page[i] = '0;
        placed_at[i]  = '0;
      end
      stamp_now = fpr_pkg::STAMP_INIT;
      errors = 0;
    endfunction

    function int pending();
      return expected_placements.size();
    endfunction

    // lookup, then oldest stamp with lowest index on ties
    function void take_request(logic [PW-1:0] page);
      placement_t    r;
      int            sel;
      bit            found;
      logic [SW-1:0] oldest;
      sel = 0;
      found = 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        if (!found && frame_used[i] && frame_page[i] == page) begin
          sel = i;
          found = 1'b1;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        r.frame = IDX_W'(sel);
        r.ev_valid = 1'b0;
        r.ev_page = '0;
      end else begin
        oldest = placed_at[0];
        for (int i = 1; i < FRAMES; i++) begin
          if (placed_at[i] < oldest) begin
            oldest = placed_at[i];
            sel = i;
          end
        end
        r.hit = 1'b0;
        r.frame = IDX_W'(sel);
        r.ev_valid = frame_used[sel];
        r.ev_page = frame_used[sel] ? frame_page[sel] : '0;
        frame_used[sel] = 1'b1;
        frame_page[sel] = page;
        placed_at[sel] = stamp_now;
      end
      stamp_now = stamp_now + 1'b1;
      expected_placements.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 60) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic got_hit, logic [IDX_W-1:0] got_frame, logic got_ev_valid,
                      logic [PW-1:0] got_ev_page);
      placement_t e;
      if (expected_placements.size() == 0) begin
        report($sformatf("result beat with nothing expected, frame %0d", got_frame));
      end else begin
        e = expected_placements.pop_front();
        if (got_hit !== e.hit)
          report($sformatf("hit got %b expected %b", got_hit, e.hit));
        if (got_frame !== e.frame)
          report($sformatf("frame_index got %0d expected %0d", got_frame, e.frame));
        if (got_ev_valid !== e.ev_valid)
          report($sformatf("evicted_valid got %b expected %b", got_ev_valid, e.ev_valid));
        if (got_ev_page !== e.ev_page)
          report($sformatf("evicted_page got %h expected %h", got_ev_page, e.ev_page));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [PW-1:0]    requested_page = '0;
  logic             busy;
  logic             done;
  logic             hit;
  logic [IDX_W-1:0] frame_index;
  logic             evicted_valid;
  logic [PW-1:0]    evicted_page;

  frame_table_sb sb;
  bit            idle_on = 1'b1;
  int            quiet_cycles = 0;
  logic [PW-1:0] pool [16];
  int            pool_n = 1;

  fifo_page_replacement uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .requested_page (requested_page),
    .done           (done),
    .hit            (hit),
    .frame_index    (frame_index),
    .evicted_valid  (evicted_valid),
    .evicted_page   (evicted_page)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(hit, frame_index, evicted_valid, evicted_page);
      if (start && !busy) sb.take_request(requested_page);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // start may drop at random on any cycle, busy or not, while idle_on is set
  task automatic send_page(logic [PW-1:0] p);
    bit go;
    requested_page <= p;
    do begin
      go = !(idle_on && $urandom_range(0, 99) < 27);
      start <= go;
      @(posedge clk);
    end while (!(go && !busy));
  endtask

  task automatic refill_pool();
    pool_n = $urandom_range(3, 14);
    for (int i = 0; i < 16; i++) begin
      case ($urandom_range(0, 9))
        0:       pool[i] = '0;
        1:       pool[i] = '1;
        default: pool[i] = PW'($urandom);
      endcase
    end
  endtask

  // mostly a working set so hits and evictions both occur
  function automatic logic [PW-1:0] pick_page();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return PW'($urandom);
    if (r < 18) return pool[$urandom_range(0, pool_n - 1)] ^ (PW'(1) << $urandom_range(0, PW - 1));
    return pool[$urandom_range(0, pool_n - 1)];
  endfunction

  initial begin
    logic [PW-1:0] directed [$];
    sb = new();
    directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF, 16'hAAAA,
                 16'h5555, 16'h1234, 16'hFFFF, 16'h4321, 16'h0000, 16'h0001, 16'hFFFF,
                 16'hFFFE, 16'h7FFF, 16'h8001, 16'h5555, 16'hAAAA, 16'h0000};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_page(directed[i]);

    refill_pool();
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      if (k % 100 == 0) refill_pool();
      idle_on = !(k >= 500 && k < 800);
      send_page(pick_page());
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (FRAMES + 6) @(posedge clk);

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/fpr_pkg.sv
src/fpr_cell.sv
src/fifo_page_replacement.sv
tb/tb.sv
